// File: rtl/core/pgfa_pkg.sv
// Shared constants, types and register map of the pressure glitch filter.
package pgfa_pkg;

   // Sample width and the fixed widths of the pressure grid
   localparam int SAMPLE_BITS   = 16;
   localparam int PRESS_BITS    = 15;
   localparam int THRESH_BITS   = 13;
   localparam int CONFIRM_BITS  = 3;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Compare width wide enough for the sample and any limit, plus sign
   localparam int CMP_BITS = ((SAMPLE_BITS > PRESS_BITS + 1) ? SAMPLE_BITS : PRESS_BITS + 1) + 1;

   // Saturation point of the consecutive-jump counter
   localparam logic [CONFIRM_BITS-1:0] JUMP_COUNT_MAX = '1;

   // Register reset values
   localparam logic [THRESH_BITS-1:0]  ALERT_THRESHOLD_RST = THRESH_BITS'(1600);
   localparam logic [PRESS_BITS-1:0]   RANGE_LIMIT_RST     = PRESS_BITS'(5280);
   localparam logic [PRESS_BITS-1:0]   JUMP_LIMIT_RST      = PRESS_BITS'(960);
   localparam logic [CONFIRM_BITS-1:0] CONFIRM_RST         = CONFIRM_BITS'(2);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_ALERT_THRESHOLD = 2'd0,
      REG_RANGE_LIMIT     = 2'd1,
      REG_JUMP_LIMIT      = 2'd2,
      REG_CONFIRMATIONS   = 2'd3
   } reg_index_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACCEPTED = 2'd0,
      ST_RANGE    = 2'd1,
      ST_GLITCH   = 2'd2
   } status_type;

endpackage

// File: rtl/core/pgfa_median.sv
// Median of three signed samples.
module pgfa_median (
   input  pgfa_pkg::sample_type sample_a,
   input  pgfa_pkg::sample_type sample_b,
   input  pgfa_pkg::sample_type sample_c,
   output pgfa_pkg::sample_type median
);
   import pgfa_pkg::*;

   sample_type lo_ab;
   sample_type hi_ab;
   sample_type hi_c;

   // Order the first pair, then bound the third sample by it
   assign lo_ab  = (sample_a > sample_b) ? sample_b : sample_a;
   assign hi_ab  = (sample_a > sample_b) ? sample_a : sample_b;
   assign hi_c   = (hi_ab > sample_c) ? sample_c : hi_ab;
   assign median = (lo_ab > hi_c) ? lo_ab : hi_c;

endmodule

// File: rtl/core/pressure_glitch_filter_alarm.sv
// Top level of the pressure glitch filter with low-pressure alert.
//
//   Channel  Direction  Handshake            Beat contents
//   req_     in         req_valid/req_stall  three signed pressure samples
//   rsp_     out        rsp_valid/rsp_stall  status, held pressure, alert
//   csr_     in/out     APB write/read       four filter registers
//
// A beat is registered with its median at the edge that accepts it and settled
// against the filter state into the output register once that register is
// free, from where its result is on rsp_; one beat can be taken every cycle
// while req_stall is low. Synchronous reset clears the filter state and loads
// register defaults. A stalled result is held in the output register while the
// next beat still enters the input register; the input stalls only when both
// registers are full and the output is stalled.
module pressure_glitch_filter_alarm (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pgfa_pkg::sample_type                   req_sample_first,
   input  pgfa_pkg::sample_type                   req_sample_second,
   input  pgfa_pkg::sample_type                   req_sample_third,
   // Result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pgfa_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [pgfa_pkg::PRESS_BITS-1:0]        rsp_held_pressure,
   output logic                                   rsp_alert,
   // Configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pgfa_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [pgfa_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [pgfa_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import pgfa_pkg::*;

   // Configuration registers
   logic [THRESH_BITS-1:0]  alert_threshold_ff;
   logic [PRESS_BITS-1:0]   range_limit_ff;
   logic [PRESS_BITS-1:0]   jump_limit_ff;
   logic [CONFIRM_BITS-1:0] confirmations_ff;
   reg_index_type           csr_index;
   logic                    csr_write;

   // Input stage
   sample_type              median_in;
   sample_type              median_ff;
   logic                    in_valid_ff;

   // Filter state
   logic [PRESS_BITS-1:0]   prev_ff;
   logic [PRESS_BITS-1:0]   prev_in;
   logic [CONFIRM_BITS-1:0] jump_count_ff;
   logic [CONFIRM_BITS-1:0] jump_count_in;
   logic                    alert_ff;
   logic                    alert_in;

   // Output stage
   logic                    out_valid_ff;
   status_type              status_ff;
   status_type              status_in;

   // Datapath
   logic                    advance;
   logic                    out_open;
   logic signed [CMP_BITS-1:0] med_wide;
   logic                    med_neg;
   logic                    over_range;
   logic [PRESS_BITS-1:0]   press;
   logic signed [PRESS_BITS+1:0] delta;
   logic [PRESS_BITS:0]     delta_abs;
   logic                    is_jump;
   logic [CONFIRM_BITS-1:0] count_bumped;
   logic                    take;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alert_threshold_ff <= ALERT_THRESHOLD_RST;
         range_limit_ff     <= RANGE_LIMIT_RST;
         jump_limit_ff      <= JUMP_LIMIT_RST;
         confirmations_ff   <= CONFIRM_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ALERT_THRESHOLD: alert_threshold_ff <= csr_pwdata[THRESH_BITS-1:0];
            REG_RANGE_LIMIT:     range_limit_ff     <= csr_pwdata[PRESS_BITS-1:0];
            REG_JUMP_LIMIT:      jump_limit_ff      <= csr_pwdata[PRESS_BITS-1:0];
            REG_CONFIRMATIONS:   confirmations_ff   <= csr_pwdata[CONFIRM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back registers
   always_comb begin
      unique case (csr_index)
         REG_ALERT_THRESHOLD: csr_prdata = CSR_DATA_BITS'(alert_threshold_ff);
         REG_RANGE_LIMIT:     csr_prdata = CSR_DATA_BITS'(range_limit_ff);
         REG_JUMP_LIMIT:      csr_prdata = CSR_DATA_BITS'(jump_limit_ff);
         REG_CONFIRMATIONS:   csr_prdata = CSR_DATA_BITS'(confirmations_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Handshake: the output register frees when empty or drained
   assign out_open  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_open;
   assign req_stall = in_valid_ff & ~out_open;

   pgfa_median u_median (
      .sample_a (req_sample_first),
      .sample_b (req_sample_second),
      .sample_c (req_sample_third),
      .median   (median_in)
   );

   // Capture the median of an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid & ~req_stall) begin
         median_ff <= median_in;
      end
   end

   // Clamp negatives and check the range limit
   assign med_wide   = CMP_BITS'(median_ff);
   assign med_neg    = median_ff[SAMPLE_BITS-1];
   assign over_range = ~med_neg &
                       (med_wide > $signed({{(CMP_BITS-PRESS_BITS){1'b0}}, range_limit_ff}));
   assign press      = med_neg ? '0 : med_wide[PRESS_BITS-1:0];

   // Measure the jump from the last accepted pressure
   assign delta     = $signed({2'b00, press}) - $signed({2'b00, prev_ff});
   assign delta_abs = delta[PRESS_BITS+1] ? (PRESS_BITS+1)'(0) - delta[PRESS_BITS:0]
                                          : delta[PRESS_BITS:0];
   assign is_jump   = delta_abs > {1'b0, jump_limit_ff};

   assign count_bumped = (jump_count_ff == JUMP_COUNT_MAX) ? jump_count_ff
                                                           : jump_count_ff + 1'b1;

   // Decide the beat and the next filter state
   always_comb begin
      prev_in       = prev_ff;
      jump_count_in = jump_count_ff;
      alert_in      = alert_ff;
      status_in     = ST_ACCEPTED;
      take          = 1'b0;
      if (over_range) begin
         status_in = ST_RANGE;
      end else begin
         jump_count_in = is_jump ? count_bumped : '0;
         take          = ~is_jump | (count_bumped >= confirmations_ff);
         if (take) begin
            prev_in  = press;
            alert_in = ({{(PRESS_BITS-THRESH_BITS){1'b0}}, alert_threshold_ff} >= press);
         end else begin
            status_in = ST_GLITCH;
         end
      end
   end

   // Advance the filter state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         jump_count_ff <= '0;
         alert_ff      <= 1'b0;
         status_ff     <= ST_ACCEPTED;
      end else begin
         if (out_open) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            prev_ff       <= prev_in;
            jump_count_ff <= jump_count_in;
            alert_ff      <= alert_in;
            status_ff     <= status_in;
         end
      end
   end

   // Held pressure always equals the last accepted pressure
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_held_pressure = prev_ff;
   assign rsp_alert         = alert_ff;

endmodule
